// ----- src/gmd_pkg.sv -----
// ---------------------------------------------------------------------------
// gmd_pkg
// Shared widths, pipeline control type and GF(2^8) helper functions for the
// masked GF(2^8) multiplier.
// ---------------------------------------------------------------------------
package gmd_pkg;

   // Field and port widths
   localparam int BYTE_WIDTH         = 8;
   localparam int SHARES_MAX         = 4;
   localparam int SHARE_BUS_WIDTH    = SHARES_MAX * BYTE_WIDTH;
   localparam int RANDOM_WIDTH       = 48;
   localparam int CLMUL_WIDTH        = 2 * BYTE_WIDTH - 1;
   localparam int MASK_ORDER_DEFAULT = 3;

   // Low byte of the AES reduction polynomial x^8+x^4+x^3+x+1
   localparam logic [BYTE_WIDTH-1:0] GF_POLY_LOW = 8'h1B;

   // Per-stage load enables, driven by the pipeline control in the top level
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } gmd_load_type;

   // Carry-less 8x8 multiply, 15-bit result
   function automatic logic [CLMUL_WIDTH-1:0] gf_clmul(
      input logic [BYTE_WIDTH-1:0] x,
      input logic [BYTE_WIDTH-1:0] y
   );
      logic [CLMUL_WIDTH-1:0] acc;
      acc = '0;
      for (int k = 0; k < BYTE_WIDTH; k++) begin
         if (y[k]) begin
            acc = acc ^ (CLMUL_WIDTH'(x) << k);
         end
      end
      return acc;
   endfunction

   // Reduce a 15-bit carry-less product modulo the AES polynomial
   function automatic logic [BYTE_WIDTH-1:0] gf_reduce(
      input logic [CLMUL_WIDTH-1:0] p
   );
      logic [CLMUL_WIDTH-1:0] r;
      logic [CLMUL_WIDTH-1:0] poly;
      r    = p;
      poly = {{(CLMUL_WIDTH-BYTE_WIDTH-1){1'b0}}, 1'b1, GF_POLY_LOW};
      for (int k = CLMUL_WIDTH - 1; k >= BYTE_WIDTH; k--) begin
         if (r[k]) begin
            r = r ^ (poly << (k - BYTE_WIDTH));
         end
      end
      return r[BYTE_WIDTH-1:0];
   endfunction

endpackage

// ----- src/gmd_mult_array.sv -----
// ---------------------------------------------------------------------------
// gmd_mult_array
// First two pipeline stages: carry-less products of every share pair, then
// reduction and masking of the cross-domain terms with their random byte.
// ---------------------------------------------------------------------------
module gmd_mult_array
   import gmd_pkg::*;
#(
   parameter int MASK_ORDER = MASK_ORDER_DEFAULT
) (
   input  logic                       clock,
   input  gmd_load_type               load,
   input  logic [SHARE_BUS_WIDTH-1:0] a_shares,
   input  logic [SHARE_BUS_WIDTH-1:0] b_shares,
   input  logic [RANDOM_WIDTH-1:0]    random_bytes,
   output logic [BYTE_WIDTH-1:0]      term [MASK_ORDER+1][MASK_ORDER+1]
);

   localparam int SHARE_COUNT = MASK_ORDER + 1;
   localparam int PAIR_COUNT  = MASK_ORDER * (MASK_ORDER + 1) / 2;

   logic [CLMUL_WIDTH-1:0]          clmul_ff [SHARE_COUNT][SHARE_COUNT];
   logic [PAIR_COUNT*BYTE_WIDTH-1:0] rand_ff;
   logic [BYTE_WIDTH-1:0]           term_ff  [SHARE_COUNT][SHARE_COUNT];

   // Stage 1: random bytes travel alongside the raw products
   always_ff @(posedge clock) begin
      if (load.s1) begin
         rand_ff <= random_bytes[PAIR_COUNT*BYTE_WIDTH-1:0];
      end
   end

   for (genvar i = 0; i < SHARE_COUNT; i++) begin : g_row
      for (genvar j = 0; j < SHARE_COUNT; j++) begin : g_col
         logic [BYTE_WIDTH-1:0] term_in;

         // Stage 1: a_i * b_j without reduction
         always_ff @(posedge clock) begin
            if (load.s1) begin
               clmul_ff[i][j] <= gf_clmul(a_shares[i*BYTE_WIDTH +: BYTE_WIDTH],
                                          b_shares[j*BYTE_WIDTH +: BYTE_WIDTH]);
            end
         end

         // Stage 2: reduce, and add the pair's fresh mask off the diagonal
         if (i == j) begin : g_inner
            assign term_in = gf_reduce(clmul_ff[i][j]);
         end else begin : g_cross
            localparam int LO  = (i < j) ? i : j;
            localparam int HI  = (i < j) ? j : i;
            localparam int IDX = LO + HI * (HI - 1) / 2;
            assign term_in = gf_reduce(clmul_ff[i][j]) ^
                             rand_ff[IDX*BYTE_WIDTH +: BYTE_WIDTH];
         end

         always_ff @(posedge clock) begin
            if (load.s2) begin
               term_ff[i][j] <= term_in;
            end
         end

         assign term[i][j] = term_ff[i][j];
      end
   end

endmodule

// ----- src/gmd_share_sum.sv -----
// ---------------------------------------------------------------------------
// gmd_share_sum
// Final stage: compresses each domain's terms into one output share and
// holds the packed result in the output register.
// ---------------------------------------------------------------------------
module gmd_share_sum
   import gmd_pkg::*;
#(
   parameter int MASK_ORDER = MASK_ORDER_DEFAULT
) (
   input  logic                       clock,
   input  gmd_load_type               load,
   input  logic [BYTE_WIDTH-1:0]      term [MASK_ORDER+1][MASK_ORDER+1],
   output logic [SHARE_BUS_WIDTH-1:0] product_shares
);

   localparam int SHARE_COUNT = MASK_ORDER + 1;

   logic [SHARE_BUS_WIDTH-1:0] product_in;
   logic [SHARE_BUS_WIDTH-1:0] product_ff;

   // XOR of all terms in domain i; unused share bytes stay zero
   always_comb begin
      product_in = '0;
      for (int i = 0; i < SHARE_COUNT; i++) begin
         for (int j = 0; j < SHARE_COUNT; j++) begin
            product_in[i*BYTE_WIDTH +: BYTE_WIDTH] =
               product_in[i*BYTE_WIDTH +: BYTE_WIDTH] ^ term[i][j];
         end
      end
   end

   // Stage 3: output register
   always_ff @(posedge clock) begin
      if (load.s3) begin
         product_ff <= product_in;
      end
   end

   assign product_shares = product_ff;

endmodule

// ----- src/masked_gf256_multiply_dom.sv -----
// ---------------------------------------------------------------------------
// masked_gf256_multiply_dom
// Pipeline: three register stages (raw products, reduced terms, output register);
// rsp_valid rises once an input transfer has passed through all three of them.
// Throughput: one multiplication per cycle while the output is not stalled; every stage advances independently.
// Back-pressure: under rsp_stall an empty stage still loads, so bubbles are
// squeezed out; req_stall rises only once all three stages are full.
// Reset: synchronous, clears the stage valid bits only; no other state.
// ---------------------------------------------------------------------------
module masked_gf256_multiply_dom
   import gmd_pkg::*;
#(
   parameter int MASK_ORDER = MASK_ORDER_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [SHARE_BUS_WIDTH-1:0] req_a_shares,
   input  logic [SHARE_BUS_WIDTH-1:0] req_b_shares,
   input  logic [RANDOM_WIDTH-1:0]    req_random_bytes,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [SHARE_BUS_WIDTH-1:0] rsp_product_shares
);

   localparam int SHARE_COUNT = MASK_ORDER + 1;

   gmd_load_type          load;
   logic                  ready1, ready2, ready3;
   logic                  valid1_ff, valid2_ff, valid3_ff;
   logic                  valid1_in, valid2_in, valid3_in;
   logic [BYTE_WIDTH-1:0] term [SHARE_COUNT][SHARE_COUNT];

   // A stage may load when empty or when its content moves on
   assign ready3 = !valid3_ff || !rsp_stall;
   assign ready2 = !valid2_ff || ready3;
   assign ready1 = !valid1_ff || ready2;

   assign load.s1 = ready1;
   assign load.s2 = ready2;
   assign load.s3 = ready3;

   assign valid1_in = ready1 ? req_valid : valid1_ff;
   assign valid2_in = ready2 ? valid1_ff : valid2_ff;
   assign valid3_in = ready3 ? valid2_ff : valid3_ff;

   // Valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         valid1_ff <= valid1_in;
         valid2_ff <= valid2_in;
         valid3_ff <= valid3_in;
      end
   end

   assign req_stall = !ready1;
   assign rsp_valid = valid3_ff;

   gmd_mult_array #(
      .MASK_ORDER (MASK_ORDER)
   ) u_mult_array (
      .clock        (clock),
      .load         (load),
      .a_shares     (req_a_shares),
      .b_shares     (req_b_shares),
      .random_bytes (req_random_bytes),
      .term         (term)
   );

   gmd_share_sum #(
      .MASK_ORDER (MASK_ORDER)
   ) u_share_sum (
      .clock          (clock),
      .load           (load),
      .term           (term),
      .product_shares (rsp_product_shares)
   );

endmodule

// ----- src/gmd_checker.sv -----
// ---------------------------------------------------------------------------
// gmd_checker
// Port-level checks for the masked GF(2^8) multiplier, bound to the top level.
// ---------------------------------------------------------------------------
module gmd_checker
   import gmd_pkg::*;
#(
   parameter int MASK_ORDER = MASK_ORDER_DEFAULT
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [SHARE_BUS_WIDTH-1:0] rsp_product_shares
);

   localparam int USED_BITS = (MASK_ORDER + 1) * BYTE_WIDTH;

   // Nothing is presented in the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

   // A held result stays put until it is taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_product_shares))
      else $error("stalled result changed or vanished");

   // With the output free, the pipeline never pushes back
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || !rsp_stall) |-> !req_stall)
      else $error("input stalled while output path is free");

   // Share bytes beyond the masking order are zero
   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({{USED_BITS{1'b0}}, rsp_product_shares} >> USED_BITS) == '0)
      else $error("unused product share byte is not zero");

endmodule

bind masked_gf256_multiply_dom gmd_checker #(
   .MASK_ORDER (MASK_ORDER)
) u_gmd_checker (.*);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the DOM-indep masked GF(2^8) multiplier. Operand
// and random shares go in over the request channel. Each accepted transfer
// is run through a local share-product predictor, and every product that
// comes back is checked against the oldest prediction. Both sides idle at
// random. One phase holds the result side off long enough to back the
// pipeline up. Another lets the pipeline drain empty before going on.
// ---------------------------------------------------------------------------
module tb;
   import gmd_pkg::*;

   localparam int ORDER        = MASK_ORDER_DEFAULT;
   localparam int PIPE_LATENCY = 3;
   localparam int IDLE_LIMIT   = 2000;
   localparam int RANDOM_ITEMS = 1880;
   localparam int LONG_HOLD    = 150;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [SHARE_BUS_WIDTH-1:0] req_a_shares;
   logic [SHARE_BUS_WIDTH-1:0] req_b_shares;
   logic [RANDOM_WIDTH-1:0]    req_random_bytes;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [SHARE_BUS_WIDTH-1:0] rsp_product_shares;

   logic [SHARE_BUS_WIDTH-1:0] expected_products[$];
   int                         error_count = 0;
   int                         items_sent = 0;
   int                         products_seen = 0;
   int                         input_stall_cycles = 0;
   int                         idle_cycles = 0;
   int                         tx_idle_max = 13;
   int                         rx_idle_max = 13;
   int                         hold_request = 0;

   masked_gf256_multiply_dom #(
      .MASK_ORDER(ORDER)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_a_shares       (req_a_shares),
      .req_b_shares       (req_b_shares),
      .req_random_bytes   (req_random_bytes),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_product_shares (rsp_product_shares)
   );

   always #5 clock = ~clock;

   // GF(2^8) product, AES polynomial, shift-and-add with xtime
   function automatic logic [BYTE_WIDTH-1:0] gf_mul_byte(
      input logic [BYTE_WIDTH-1:0] x,
      input logic [BYTE_WIDTH-1:0] y
   );
      logic [BYTE_WIDTH-1:0] acc;
      logic [BYTE_WIDTH-1:0] sh;
      acc = '0;
      sh  = x;
      for (int k = 0; k < BYTE_WIDTH; k++) begin
         if (y[k]) begin
            acc = acc ^ sh;
         end
         sh = {sh[BYTE_WIDTH-2:0], 1'b0} ^ (sh[BYTE_WIDTH-1] ? GF_POLY_LOW : 8'h00);
      end
      return acc;
   endfunction

   // Output shares: inner product plus masked cross products per share domain
   function automatic logic [SHARE_BUS_WIDTH-1:0] dom_product(
      input logic [SHARE_BUS_WIDTH-1:0] a,
      input logic [SHARE_BUS_WIDTH-1:0] b,
      input logic [RANDOM_WIDTH-1:0]    r
   );
      logic [SHARE_BUS_WIDTH-1:0] prod;
      logic [BYTE_WIDTH-1:0]      share;
      logic [BYTE_WIDTH-1:0]      ai;
      int                         lo;
      int                         hi;
      prod = '0;
      for (int i = 0; i <= ORDER; i++) begin
         ai    = a[BYTE_WIDTH*i +: BYTE_WIDTH];
         share = '0;
         for (int j = 0; j <= ORDER; j++) begin
            share = share ^ gf_mul_byte(ai, b[BYTE_WIDTH*j +: BYTE_WIDTH]);
            if (i != j) begin
               lo    = (i < j) ? i : j;
               hi    = (i < j) ? j : i;
               share = share ^ r[BYTE_WIDTH*(lo + hi*(hi-1)/2) +: BYTE_WIDTH];
            end
         end
         prod[BYTE_WIDTH*i +: BYTE_WIDTH] = share;
      end
      return prod;
   endfunction

   // Share word with corner bytes mixed in now and then
   function automatic logic [SHARE_BUS_WIDTH-1:0] draw_shares();
      logic [SHARE_BUS_WIDTH-1:0] w;
      w = $urandom;
      for (int k = 0; k < SHARES_MAX; k++) begin
         case ($urandom_range(0, 15))
            0: w[BYTE_WIDTH*k +: BYTE_WIDTH] = 8'h00;
            1: w[BYTE_WIDTH*k +: BYTE_WIDTH] = 8'hFF;
            2: w[BYTE_WIDTH*k +: BYTE_WIDTH] = 8'h01;
            3: w[BYTE_WIDTH*k +: BYTE_WIDTH] = 8'h80;
            default: ;
         endcase
      end
      return w;
   endfunction

   function automatic logic [RANDOM_WIDTH-1:0] draw_random();
      return {16'($urandom), 32'($urandom)};
   endfunction

   task automatic report_mismatch(
      input string                      what,
      input logic [SHARE_BUS_WIDTH-1:0] got,
      input logic [SHARE_BUS_WIDTH-1:0] want
   );
      $display("ERROR @%0t: %s: got %h want %h", $realtime, what, got, want);
      error_count++;
   endtask

   // Offer one multiplication after a random gap; returns at the next falling edge
   task automatic send_operands(
      input logic [SHARE_BUS_WIDTH-1:0] a,
      input logic [SHARE_BUS_WIDTH-1:0] b,
      input logic [RANDOM_WIDTH-1:0]    r
   );
      int gap;
      gap = $urandom_range(0, tx_idle_max);
      if (gap > 0) begin
         req_valid        <= 1'b0;
         req_a_shares     <= $urandom;
         req_b_shares     <= $urandom;
         req_random_bytes <= draw_random();
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_a_shares     <= a;
      req_b_shares     <= b;
      req_random_bytes <= r;
      do @(posedge clock); while (req_stall);
      expected_products.push_back(dom_product(a, b, r));
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_products.size() != 0) @(negedge clock);
   endtask

   // Result side: random stall per transfer, long hold on request
   initial begin : result_sink
      int stall_left;
      stall_left = 0;
      rsp_stall  = 1'b1;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            stall_left   = hold_request;
            hold_request = 0;
         end
         rsp_stall <= (stall_left > 0);
         if (stall_left > 0) stall_left--;
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) stall_left = $urandom_range(0, rx_idle_max);
      end
   end

   // Compare each result transfer with the oldest prediction
   always @(posedge clock) begin : result_check
      logic [SHARE_BUS_WIDTH-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         products_seen++;
         if (expected_products.size() == 0) begin
            report_mismatch("unexpected product_shares", rsp_product_shares, 'x);
         end else begin
            want = expected_products.pop_front();
            if (rsp_product_shares !== want)
               report_mismatch("product_shares", rsp_product_shares, want);
         end
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (req_valid && req_stall) input_stall_cycles++;
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("ERROR: no transfer for %0d cycles, %0d products outstanding",
                     IDLE_LIMIT, expected_products.size());
            $display("masked_gf256_multiply_dom test failed");
            $finish;
         end
      end
   end

   // Field extremes, zero operands, reduction cases and mask-only products
   task automatic test_directed();
      send_operands(32'h0000_0000, 32'h0000_0000, 48'h0);
      send_operands(32'h0000_0000, 32'hFFFF_FFFF, 48'h0);
      send_operands(32'hFFFF_FFFF, 32'h0000_0000, 48'h0);
      send_operands(32'h0000_0000, 32'h0000_0000, 48'hFFFF_FFFF_FFFF);
      send_operands(32'h0000_0000, $urandom, draw_random());
      send_operands($urandom, 32'h0000_0000, draw_random());
      send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
      send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'h0);
      send_operands(32'h0101_0101, $urandom, 48'h0);
      send_operands(32'h8080_8080, 32'h8080_8080, 48'h0);
      send_operands(32'h5555_5555, 32'hAAAA_AAAA, 48'h5555_AAAA_55AA);
      send_operands(32'hAAAA_AAAA, 32'h5555_5555, 48'hAAAA_5555_AA55);
      send_operands(32'h0000_00C3, 32'h0000_007E, 48'h0);
      send_operands(32'h5300_0000, 32'hCA00_0000, 48'h0);
      for (int k = 0; k < SHARES_MAX; k++)
         send_operands(32'h80 << (BYTE_WIDTH*k), 32'hFF << (BYTE_WIDTH*k),
                       48'h1 << (BYTE_WIDTH*k));
      send_operands($urandom, $urandom, 48'h0);
      send_operands($urandom, $urandom, draw_random());
   endtask

   // Hold the result side off while the sender keeps offering
   task automatic test_backpressure();
      wait_drained();
      tx_idle_max  = 0;
      hold_request = LONG_HOLD;
      repeat (40) send_operands(draw_shares(), draw_shares(), draw_random());
      tx_idle_max = 13;
   endtask

   // Let the pipeline empty out between two bursts
   task automatic test_drain_pause();
      repeat (6) send_operands(draw_shares(), draw_shares(), draw_random());
      wait_drained();
      repeat (6) send_operands(draw_shares(), draw_shares(), draw_random());
   endtask

   // Random operands, idling mode changes every hundred transfers
   task automatic test_random();
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0) begin
            case ((n / 100) % 4)
               0: begin tx_idle_max = 13; rx_idle_max = 13; end
               1: begin tx_idle_max = 0;  rx_idle_max = 0;  end
               2: begin tx_idle_max = 0;  rx_idle_max = 13; end
               default: begin tx_idle_max = 13; rx_idle_max = 0; end
            endcase
         end
         send_operands(draw_shares(), draw_shares(), draw_random());
      end
      tx_idle_max = 13;
      rx_idle_max = 13;
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_a_shares     = '0;
      req_b_shares     = '0;
      req_random_bytes = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_backpressure();
      test_drain_pause();
      test_random();

      // drain and allow for stray results
      wait_drained();
      repeat (PIPE_LATENCY + 5) @(posedge clock);

      $display("Run covered %0d masked multiplications, %0d products checked, %0d errors.",
               items_sent, products_seen, error_count);
      $display("Input held off by the block for %0d cycles under result back-pressure.",
               input_stall_cycles);
      if (error_count == 0) begin
         $display("masked_gf256_multiply_dom test passed");
      end else begin
         $display("masked_gf256_multiply_dom test failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
src/gmd_pkg.sv
src/gmd_mult_array.sv
src/gmd_share_sum.sv
src/masked_gf256_multiply_dom.sv
src/gmd_checker.sv
tb/tb.sv
